// File: rtl/core/gpup_pkg.sv
// shared types, widths and helper functions of the gravity particle update core
package gpup_pkg;

  // vector component width and port packing
  localparam int CW         = 21;
  localparam int VEC_PORT_W = 63;
  localparam int LIFE_W     = 24;
  localparam int DT_W       = 16;
  localparam int ACCEL_W    = 21;
  localparam int COLOR_W    = 64;
  localparam int CCH_W      = 16;
  localparam int NCH        = COLOR_W / CCH_W;
  localparam int PAIR_W     = 32;
  localparam int SIZE_W     = PAIR_W - 1;

  // unit vector in Q.16, magnitude up to one
  localparam int UNIT_FRAC  = 16;
  localparam int UW         = UNIT_FRAC + 2;

  // length and normalize datapath
  localparam int SQ_W       = 2 * CW;
  localparam int ROOT_W     = CW;
  localparam int DIV_STEPS  = UNIT_FRAC + 1;

  // acceleration datapath
  localparam int PROD_W     = ACCEL_W + UW;
  localparam int ACC_W      = PROD_W - UNIT_FRAC + 2;
  localparam int WIDE_W     = 64;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP = 2'd0,
    CFG_GRAVITY   = 2'd1,
    CFG_EMITTER   = 2'd2,
    CFG_FOLLOW    = 2'd3
  } cfg_idx_e;

  typedef logic signed [CW-1:0]      comp_t;
  typedef comp_t                     vec_t [3];
  typedef logic signed [UW-1:0]      unit_t;
  typedef unit_t                     unit_vec_t [3];
  typedef logic signed [ACCEL_W-1:0] accel_t;

  // per-particle data that travels alongside the normalize datapath
  typedef struct {
    logic                    dead;
    logic                    origin;
    logic [LIFE_W-1:0]       life;
    vec_t                    p;
    vec_t                    v;
    vec_t                    st;
    accel_t                  ar;
    accel_t                  at;
    logic [COLOR_W-1:0]      color;
    logic [SIZE_W-1:0]       size;
    logic signed [PAIR_W-1:0] rot;
  } side_t;

  // one finished result
  typedef struct packed {
    logic                     alive;
    logic [LIFE_W-1:0]        life;
    logic [VEC_PORT_W-1:0]    pos;
    logic [VEC_PORT_W-1:0]    vel;
    logic [VEC_PORT_W-1:0]    draw;
    logic [COLOR_W-1:0]       color;
    logic [SIZE_W-1:0]        size;
    logic signed [PAIR_W-1:0] rot;
  } result_t;

  localparam logic signed [WIDE_W-1:0] COMP_MAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [WIDE_W-1:0] COMP_MIN = -COMP_MAX - 64'sd1;
  localparam logic signed [WIDE_W-1:0] CCH_MAX  = (64'sd1 <<< (CCH_W - 1)) - 64'sd1;
  localparam logic signed [WIDE_W-1:0] CCH_MIN  = -CCH_MAX - 64'sd1;
  localparam logic signed [WIDE_W-1:0] W32_MAX  = (64'sd1 <<< (PAIR_W - 1)) - 64'sd1;
  localparam logic signed [WIDE_W-1:0] W32_MIN  = -W32_MAX - 64'sd1;

  // split a packed port word into signed components, x lowest
  function automatic vec_t unpack_vec(input logic [VEC_PORT_W-1:0] w);
    vec_t r;
    for (int i = 0; i < 3; i++) begin
      r[i] = comp_t'(w[i*CW +: CW]);
    end
    return r;
  endfunction

  // pack components back, upper bits zero
  function automatic logic [VEC_PORT_W-1:0] pack_vec(input vec_t c);
    logic [VEC_PORT_W-1:0] r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      r[i*CW +: CW] = c[i];
    end
    return r;
  endfunction

  function automatic comp_t sat_comp(input logic signed [WIDE_W-1:0] x);
    comp_t r;
    if (x > COMP_MAX) r = comp_t'(COMP_MAX);
    else if (x < COMP_MIN) r = comp_t'(COMP_MIN);
    else r = comp_t'(x);
    return r;
  endfunction

  function automatic logic signed [CCH_W-1:0] sat_cch(input logic signed [WIDE_W-1:0] x);
    logic signed [CCH_W-1:0] r;
    if (x > CCH_MAX) r = CCH_W'(CCH_MAX);
    else if (x < CCH_MIN) r = CCH_W'(CCH_MIN);
    else r = CCH_W'(x);
    return r;
  endfunction

  function automatic logic signed [PAIR_W-1:0] sat_w32(input logic signed [WIDE_W-1:0] x);
    logic signed [PAIR_W-1:0] r;
    if (x > W32_MAX) r = PAIR_W'(W32_MAX);
    else if (x < W32_MIN) r = PAIR_W'(W32_MIN);
    else r = PAIR_W'(x);
    return r;
  endfunction

endpackage

// File: rtl/core/gpup_sqrt.sv
// pipelined integer square root, one root bit per stage
module gpup_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [gpup_pkg::SQ_W-1:0]   sum_i,
  output logic                        valid_o,
  output logic [gpup_pkg::ROOT_W-1:0] root_o
);

  localparam int N  = gpup_pkg::ROOT_W;
  localparam int RW = N + 1;
  localparam int SW = gpup_pkg::SQ_W;

  logic [N-1:0]  vld_q;
  logic [RW-1:0] rem_q  [N];
  logic [N-1:0]  root_q [N];
  logic [SW-1:0] src_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic          vin;
    logic [RW-1:0] rem_in;
    logic [N-1:0]  root_in;
    logic [SW-1:0] src_in;
    logic [RW+1:0] trial_rem;
    logic [RW+1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign vin     = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign src_in  = sum_i;
    end else begin : g_next
      assign vin     = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign src_in  = src_q[k-1];
    end

    // bring down the next bit pair and try a one bit
    assign trial_rem = {rem_in, src_in[SW-1 -: 2]};
    assign trial     = {1'b0, root_in, 2'b01};
    assign take      = trial_rem >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? RW'(trial_rem - trial) : RW'(trial_rem);
        root_q[k] <= {root_in[N-2:0], take};
        src_q[k]  <= {src_in[SW-3:0], 2'b00};
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];

endmodule

// File: rtl/core/gpup_div.sv
// pipelined restoring divider, forms the unit vector one quotient bit per stage
module gpup_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [gpup_pkg::ROOT_W-1:0] len_i,
  input  gpup_pkg::vec_t              p_i,
  output logic                        valid_o,
  output gpup_pkg::unit_vec_t         u_o
);

  localparam int N  = gpup_pkg::DIV_STEPS;
  localparam int LW = gpup_pkg::ROOT_W;
  localparam int CW = gpup_pkg::CW;

  logic [N-1:0]  vld_q;
  logic [LW-1:0] len_q [N];
  logic [LW-1:0] rem_q [N][3];
  logic [N-1:0]  quo_q [N][3];
  logic [2:0]    neg_q [N];

  // magnitude of each component, most negative value maps to 2^(CW-1)
  logic [CW-1:0] mag [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = p_i[i][CW-1] ? CW'(-p_i[i]) : CW'(p_i[i]);
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic          vin;
    logic [LW-1:0] len_in;
    logic [2:0]    neg_in;
    logic [LW-1:0] rem_in [3];
    logic [N-1:0]  quo_in [3];
    logic [2:0]    nb;

    if (k == 0) begin : g_first
      assign vin    = valid_i;
      assign len_in = len_i;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign neg_in[i] = p_i[i][CW-1];
        assign rem_in[i] = LW'(mag[i] >> 1);
        assign quo_in[i] = '0;
        assign nb[i]     = mag[i][0];
      end
    end else begin : g_next
      assign vin    = vld_q[k-1];
      assign len_in = len_q[k-1];
      assign neg_in = neg_q[k-1];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = rem_q[k-1][i];
        assign quo_in[i] = quo_q[k-1][i];
        assign nb[i]     = 1'b0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    // one compare and subtract per lane
    for (genvar i = 0; i < 3; i++) begin : g_lane_step
      logic [LW:0] trial;
      logic        take;
      assign trial = {rem_in[i], nb[i]};
      assign take  = trial >= {1'b0, len_in};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][i] <= take ? LW'(trial - {1'b0, len_in}) : LW'(trial);
          quo_q[k][i] <= {quo_in[i][N-2:0], take};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[k] <= len_in;
        neg_q[k] <= neg_in;
      end
    end
  end

  // restore the sign, truncation toward zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_o[i] = neg_q[N-1][i] ? -gpup_pkg::unit_t'({1'b0, quo_q[N-1][i]})
                             : gpup_pkg::unit_t'({1'b0, quo_q[N-1][i]});
    end
  end

  assign valid_o = vld_q[N-1];

endmodule

// File: rtl/core/gpup_kin.sv
// acceleration, velocity and position integration stages with result assembly
module gpup_kin (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  gpup_pkg::unit_vec_t             u_i,
  input  gpup_pkg::side_t                 side_i,
  input  logic [gpup_pkg::DT_W-1:0]       dt_i,
  input  logic [gpup_pkg::VEC_PORT_W-1:0] grav_i,
  input  logic [gpup_pkg::VEC_PORT_W-1:0] emit_i,
  input  logic                            follow_i,
  output logic                            valid_o,
  output gpup_pkg::result_t               res_o
);

  localparam int NS   = 6;
  localparam int AD_W = gpup_pkg::ACC_W + gpup_pkg::DT_W + 1;
  localparam int VD_W = gpup_pkg::CW + gpup_pkg::DT_W + 1;
  localparam int UF   = gpup_pkg::UNIT_FRAC;
  localparam int WW   = gpup_pkg::WIDE_W;

  logic signed [gpup_pkg::DT_W:0] dts;
  gpup_pkg::vec_t      g;
  gpup_pkg::vec_t      em;
  gpup_pkg::unit_vec_t um;
  gpup_pkg::unit_vec_t tv;
  gpup_pkg::vec_t      dp;

  logic [NS-1:0]                         vld_q;
  gpup_pkg::side_t                       sd_q [NS];
  logic signed [gpup_pkg::PROD_W-1:0]    pr_q [3];
  logic signed [gpup_pkg::PROD_W-1:0]    pt_q [3];
  logic signed [gpup_pkg::ACC_W-1:0]     acc_q [3];
  logic signed [AD_W-1:0]                ad_q [3];
  logic signed [VD_W-1:0]                vd_q [3];
  gpup_pkg::vec_t                        vn4_q;
  gpup_pkg::vec_t                        vn5_q;
  gpup_pkg::vec_t                        vn6_q;
  gpup_pkg::vec_t                        np_q;

  assign dts = $signed({1'b0, dt_i});

  // radial vector zero at the origin, tangential is a quarter turn in xy
  always_comb begin
    g  = gpup_pkg::unpack_vec(grav_i);
    em = gpup_pkg::unpack_vec(emit_i);
    for (int i = 0; i < 3; i++) begin
      um[i] = side_i.origin ? '0 : u_i[i];
    end
    tv[0] = -um[1];
    tv[1] = um[0];
    tv[2] = um[2];
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  // arithmetic stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[0] <= side_i;
      for (int k = 1; k < NS; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        pr_q[i]  <= side_i.ar * um[i];
        pt_q[i]  <= side_i.at * tv[i];
        acc_q[i] <= gpup_pkg::ACC_W'(pr_q[i] >>> UF) + gpup_pkg::ACC_W'(pt_q[i] >>> UF)
                  + gpup_pkg::ACC_W'(g[i]);
        ad_q[i]  <= acc_q[i] * dts;
        vn4_q[i] <= gpup_pkg::sat_comp(WW'(sd_q[2].v[i]) + WW'(ad_q[i] >>> UF));
        vd_q[i]  <= vn4_q[i] * dts;
        vn5_q[i] <= vn4_q[i];
        np_q[i]  <= gpup_pkg::sat_comp(WW'(sd_q[4].p[i]) + WW'(vd_q[i] >>> UF));
        vn6_q[i] <= vn5_q[i];
      end
    end
  end

  // draw position and result word, all zero for a dead particle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dp[i] = follow_i ? gpup_pkg::sat_comp(WW'(np_q[i]) + WW'(em[i]) - WW'(sd_q[NS-1].st[i]))
                       : np_q[i];
    end
    res_o = '0;
    if (!sd_q[NS-1].dead) begin
      res_o.alive = 1'b1;
      res_o.life  = sd_q[NS-1].life;
      res_o.pos   = gpup_pkg::pack_vec(np_q);
      res_o.vel   = gpup_pkg::pack_vec(vn6_q);
      res_o.draw  = gpup_pkg::pack_vec(dp);
      res_o.color = sd_q[NS-1].color;
      res_o.size  = sd_q[NS-1].size;
      res_o.rot   = sd_q[NS-1].rot;
    end
  end

  assign valid_o = vld_q[NS-1];

endmodule

// File: rtl/core/gpup_obuf.sv
// two-entry output buffer that decouples the pipeline from the result channel
module gpup_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gpup_pkg::result_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              ready_i,
  output gpup_pkg::result_t data_o
);

  gpup_pkg::result_t mem_q [2];
  logic              wr_q;
  logic              rd_q;
  logic [1:0]        cnt_q;
  logic              pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o & ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// File: rtl/core/gravity_particle_update_core.sv
// gravity-mode particle update core, top level
// throughput: one particle per cycle while the output buffer is not full, set by the
//   21-stage square root and 17-stage divider pipelines that sit in the length and
//   normalize path
// a two-entry output buffer lets input requests continue while a result waits
// reset clears all valid bits, the output buffer and the configuration registers
module gravity_particle_update_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gpup_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gpup_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gpup_pkg::LIFE_W-1:0]       life_left_i,
  input  logic [gpup_pkg::VEC_PORT_W-1:0]   local_position_i,
  input  logic [gpup_pkg::VEC_PORT_W-1:0]   velocity_i,
  input  logic [gpup_pkg::VEC_PORT_W-1:0]   start_position_i,
  input  logic signed [gpup_pkg::ACCEL_W-1:0] radial_accel_i,
  input  logic signed [gpup_pkg::ACCEL_W-1:0] tangential_accel_i,
  input  logic [gpup_pkg::COLOR_W-1:0]      color_i,
  input  logic [gpup_pkg::COLOR_W-1:0]      color_step_i,
  input  logic [2*gpup_pkg::PAIR_W-1:0]     size_pair_i,
  input  logic [2*gpup_pkg::PAIR_W-1:0]     spin_pair_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              alive_o,
  output logic [gpup_pkg::LIFE_W-1:0]       new_life_left_o,
  output logic [gpup_pkg::VEC_PORT_W-1:0]   new_local_position_o,
  output logic [gpup_pkg::VEC_PORT_W-1:0]   new_velocity_o,
  output logic [gpup_pkg::VEC_PORT_W-1:0]   draw_position_o,
  output logic [gpup_pkg::COLOR_W-1:0]      new_color_o,
  output logic [gpup_pkg::SIZE_W-1:0]       new_size_o,
  output logic signed [gpup_pkg::PAIR_W-1:0] new_rotation_o
);

  localparam int SIDE_N = gpup_pkg::ROOT_W + gpup_pkg::DIV_STEPS;
  localparam int CP_W   = gpup_pkg::CCH_W + gpup_pkg::DT_W + 1;
  localparam int PP_W   = gpup_pkg::PAIR_W + gpup_pkg::DT_W + 1;
  localparam int PW     = gpup_pkg::PAIR_W;
  localparam int CHW    = gpup_pkg::CCH_W;
  localparam int UF     = gpup_pkg::UNIT_FRAC;
  localparam int WW     = gpup_pkg::WIDE_W;

  // configuration registers
  logic [gpup_pkg::DT_W-1:0]       dt_q;
  logic [gpup_pkg::VEC_PORT_W-1:0] grav_q;
  logic [gpup_pkg::VEC_PORT_W-1:0] emit_q;
  logic                            follow_q;

  logic en;
  logic obuf_full;
  logic signed [gpup_pkg::DT_W:0] dts;

  // input stage
  logic                            s1_v_q;
  logic [gpup_pkg::LIFE_W-1:0]     s1_life_q;
  logic [gpup_pkg::VEC_PORT_W-1:0] s1_pos_q;
  logic [gpup_pkg::VEC_PORT_W-1:0] s1_vel_q;
  logic [gpup_pkg::VEC_PORT_W-1:0] s1_st_q;
  gpup_pkg::accel_t                s1_ar_q;
  gpup_pkg::accel_t                s1_at_q;
  logic [gpup_pkg::COLOR_W-1:0]    s1_color_q;
  logic [gpup_pkg::COLOR_W-1:0]    s1_cstep_q;
  logic [2*PW-1:0]                 s1_size_q;
  logic [2*PW-1:0]                 s1_spin_q;

  // square and rate product stage
  logic                            s2_v_q;
  logic                            s2_dead_q;
  logic [gpup_pkg::LIFE_W-1:0]     s2_life_q;
  logic [gpup_pkg::VEC_PORT_W-1:0] s2_pos_q;
  logic [gpup_pkg::VEC_PORT_W-1:0] s2_vel_q;
  logic [gpup_pkg::VEC_PORT_W-1:0] s2_st_q;
  gpup_pkg::accel_t                s2_ar_q;
  gpup_pkg::accel_t                s2_at_q;
  logic [gpup_pkg::COLOR_W-1:0]    s2_color_q;
  logic signed [PW-1:0]            s2_sz_q;
  logic signed [PW-1:0]            s2_rot_q;
  logic [gpup_pkg::SQ_W-1:0]       sq_q [3];
  logic signed [CP_W-1:0]          cp_q [gpup_pkg::NCH];
  logic signed [PP_W-1:0]          szp_q;
  logic signed [PP_W-1:0]          rotp_q;

  // sum and side data stage
  logic                            s3_v_q;
  logic [gpup_pkg::SQ_W-1:0]       sum_q;
  gpup_pkg::side_t                 s3_side_q;
  gpup_pkg::side_t                 s3_side_d;

  gpup_pkg::vec_t                  s1_p;
  logic signed [CHW-1:0]           dc [gpup_pkg::NCH];
  logic signed [CHW-1:0]           cb [gpup_pkg::NCH];
  logic signed [PW-1:0]            szw;

  // delay line alongside square root and divider
  gpup_pkg::side_t                 side_q [SIDE_N];

  logic                            sqrt_v;
  logic [gpup_pkg::ROOT_W-1:0]     sqrt_len;
  logic                            div_v;
  gpup_pkg::unit_vec_t             div_u;
  logic                            kin_v;
  gpup_pkg::result_t               kin_res;
  gpup_pkg::result_t               out_res;

  assign cfg_ready_o = 1'b1;
  assign en          = ~obuf_full;
  assign in_ready_o  = en;
  assign dts         = $signed({1'b0, dt_q});

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q     <= '0;
      grav_q   <= '0;
      emit_q   <= '0;
      follow_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gpup_pkg::CFG_TIME_STEP: dt_q     <= cfg_data_i[gpup_pkg::DT_W-1:0];
        gpup_pkg::CFG_GRAVITY:   grav_q   <= cfg_data_i[gpup_pkg::VEC_PORT_W-1:0];
        gpup_pkg::CFG_EMITTER:   emit_q   <= cfg_data_i[gpup_pkg::VEC_PORT_W-1:0];
        gpup_pkg::CFG_FOLLOW:    follow_q <= cfg_data_i[0];
        default:                 follow_q <= follow_q;
      endcase
    end
  end

  // front stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_comb begin
    s1_p = gpup_pkg::unpack_vec(s1_pos_q);
    for (int c = 0; c < gpup_pkg::NCH; c++) begin
      dc[c] = s1_cstep_q[c*CHW +: CHW];
      cb[c] = s2_color_q[c*CHW +: CHW];
    end
  end

  // input capture, squares, rate products, sum and side data delay line
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_life_q  <= life_left_i;
      s1_pos_q   <= local_position_i;
      s1_vel_q   <= velocity_i;
      s1_st_q    <= start_position_i;
      s1_ar_q    <= radial_accel_i;
      s1_at_q    <= tangential_accel_i;
      s1_color_q <= color_i;
      s1_cstep_q <= color_step_i;
      s1_size_q  <= size_pair_i;
      s1_spin_q  <= spin_pair_i;

      s2_dead_q  <= s1_life_q <= gpup_pkg::LIFE_W'(dt_q);
      s2_life_q  <= s1_life_q - gpup_pkg::LIFE_W'(dt_q);
      s2_pos_q   <= s1_pos_q;
      s2_vel_q   <= s1_vel_q;
      s2_st_q    <= s1_st_q;
      s2_ar_q    <= s1_ar_q;
      s2_at_q    <= s1_at_q;
      s2_color_q <= s1_color_q;
      s2_sz_q    <= s1_size_q[PW-1:0];
      s2_rot_q   <= s1_spin_q[PW-1:0];
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= s1_p[i] * s1_p[i];
      end
      for (int c = 0; c < gpup_pkg::NCH; c++) begin
        cp_q[c] <= dc[c] * dts;
      end
      szp_q  <= $signed(s1_size_q[2*PW-1:PW]) * dts;
      rotp_q <= $signed(s1_spin_q[2*PW-1:PW]) * dts;

      sum_q     <= sq_q[0] + sq_q[1] + sq_q[2];
      s3_side_q <= s3_side_d;

      side_q[0] <= s3_side_q;
      for (int k = 1; k < SIDE_N; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // colour, size and rotation finish early and ride along
  always_comb begin
    s3_side_d.dead   = s2_dead_q;
    s3_side_d.life   = s2_life_q;
    s3_side_d.p      = gpup_pkg::unpack_vec(s2_pos_q);
    s3_side_d.v      = gpup_pkg::unpack_vec(s2_vel_q);
    s3_side_d.st     = gpup_pkg::unpack_vec(s2_st_q);
    s3_side_d.ar     = s2_ar_q;
    s3_side_d.at     = s2_at_q;
    s3_side_d.origin = (s3_side_d.p[0] == '0) && (s3_side_d.p[1] == '0)
                    && (s3_side_d.p[2] == '0);
    s3_side_d.color  = '0;
    for (int c = 0; c < gpup_pkg::NCH; c++) begin
      s3_side_d.color[c*CHW +: CHW] = gpup_pkg::sat_cch(WW'(cb[c]) + WW'(cp_q[c] >>> UF));
    end
    szw            = gpup_pkg::sat_w32(WW'(s2_sz_q) + WW'(szp_q >>> UF));
    s3_side_d.size = szw[PW-1] ? '0 : szw[gpup_pkg::SIZE_W-1:0];
    s3_side_d.rot  = gpup_pkg::sat_w32(WW'(s2_rot_q) + WW'(rotp_q >>> UF));
  end

  // vector length
  gpup_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .sum_i   (sum_q),
    .valid_o (sqrt_v),
    .root_o  (sqrt_len)
  );

  // unit vector
  gpup_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_v),
    .len_i   (sqrt_len),
    .p_i     (side_q[gpup_pkg::ROOT_W-1].p),
    .valid_o (div_v),
    .u_o     (div_u)
  );

  // accelerate and integrate
  gpup_kin u_kin (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (div_v),
    .u_i      (div_u),
    .side_i   (side_q[SIDE_N-1]),
    .dt_i     (dt_q),
    .grav_i   (grav_q),
    .emit_i   (emit_q),
    .follow_i (follow_q),
    .valid_o  (kin_v),
    .res_o    (kin_res)
  );

  // output buffer
  gpup_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (kin_v & en),
    .data_i  (kin_res),
    .full_o  (obuf_full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res)
  );

  assign alive_o              = out_res.alive;
  assign new_life_left_o      = out_res.life;
  assign new_local_position_o = out_res.pos;
  assign new_velocity_o       = out_res.vel;
  assign draw_position_o      = out_res.draw;
  assign new_color_o          = out_res.color;
  assign new_size_o           = out_res.size;
  assign new_rotation_o       = out_res.rot;

endmodule

// File: rtl/core/gpup_chk.sv
// port-level checker for the particle update core and its bind
module gpup_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              alive_o,
  input logic [gpup_pkg::LIFE_W-1:0]       new_life_left_o,
  input logic [gpup_pkg::VEC_PORT_W-1:0]   new_local_position_o,
  input logic [gpup_pkg::COLOR_W-1:0]      new_color_o,
  input logic [gpup_pkg::SIZE_W-1:0]       new_size_o,
  input logic signed [gpup_pkg::PAIR_W-1:0] new_rotation_o
);

  // a stalled result request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_life_left_o)
      && $stable(alive_o))
    else $error("output request changed while stalled");

  // a dropped particle carries an all-zero result
  a_dead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !alive_o |-> new_life_left_o == '0 && new_local_position_o == '0
      && new_color_o == '0 && new_size_o == '0 && new_rotation_o == '0)
    else $error("dead particle result not cleared");

  // a live particle always has some life left
  a_alive_life: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alive_o |-> new_life_left_o != '0)
    else $error("live particle with zero life");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output request right after reset");

endmodule

bind gravity_particle_update_core gpup_chk u_gpup_chk (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .alive_o              (alive_o),
  .new_life_left_o      (new_life_left_o),
  .new_local_position_o (new_local_position_o),
  .new_color_o          (new_color_o),
  .new_size_o           (new_size_o),
  .new_rotation_o       (new_rotation_o)
);

// File: test/gravity_particle_update_core_tb.sv
// testbench for the gravity particle update core: random and directed particles checked against a local predictor
module gravity_particle_update_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM    = 950;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 80;

  // one particle request and one result
  typedef struct {
    logic [23:0] life;
    logic [62:0] pos, vel, st;
    logic signed [20:0] ar, at;
    logic [63:0] col, dcol, size, spin;
  } particle_t;

  typedef struct {
    logic        alive;
    logic [23:0] life;
    logic [62:0] pos, vel, draw;
    logic [63:0] col;
    logic [30:0] size;
    logic [31:0] rot;
  } update_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [gpup_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gpup_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  particle_t cur;
  logic alive;
  logic [23:0] o_life;
  logic [62:0] o_pos, o_vel, o_draw;
  logic [63:0] o_col;
  logic [30:0] o_size;
  logic signed [31:0] o_rot;

  int errors;
  int cycles;
  bit rx_hold;
  bit rx_calm;
  bit tx_calm;

  // configuration mirror
  logic [15:0] dt_q;
  logic [62:0] grav_q, emit_q;
  logic        follow_q;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic longint fshr16(input longint x);
    return x >>> 16;
  endfunction

  function automatic longint satw(input longint x, input int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  function automatic longint comp(input logic [62:0] w, input int i);
    logic signed [20:0] c;
    c = w[i*21 +: 21];
    return longint'(c);
  endfunction

  function automatic longint root(input longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // particle update as the block computes it
  function automatic update_t advance_particle(input particle_t q);
    update_t r;
    longint dt, p[3], v[3], u[3], t[3], np, acc, len, c, dc, sz, rot;
    longint unsigned s;
    logic signed [15:0] c16, d16;
    logic signed [31:0] a32, b32;
    r = '{default: '0};
    dt = longint'(dt_q);
    if (q.life <= {8'd0, dt_q}) return r;
    for (int i = 0; i < 3; i++) begin
      p[i] = comp(q.pos, i);
      v[i] = comp(q.vel, i);
      u[i] = 0;
    end
    if (p[0] != 0 || p[1] != 0 || p[2] != 0) begin
      s = 0;
      for (int i = 0; i < 3; i++) s += longint'(p[i] * p[i]);
      len = longint'(root(s));
      for (int i = 0; i < 3; i++) u[i] = (p[i] * 65536) / len;
    end
    t[0] = -u[1];
    t[1] = u[0];
    t[2] = u[2];
    for (int i = 0; i < 3; i++) begin
      acc = fshr16(longint'(q.ar) * u[i]) + fshr16(longint'(q.at) * t[i]) + comp(grav_q, i);
      v[i] = satw(v[i] + fshr16(acc * dt), 21);
      np = satw(p[i] + fshr16(v[i] * dt), 21);
      r.vel[i*21 +: 21] = v[i][20:0];
      r.pos[i*21 +: 21] = np[20:0];
      r.draw[i*21 +: 21] = follow_q ?
        21'(satw(np + comp(emit_q, i) - comp(q.st, i), 21)) : np[20:0];
    end
    for (int i = 0; i < 4; i++) begin
      c16 = q.col[16*i +: 16];
      d16 = q.dcol[16*i +: 16];
      c = satw(longint'(c16) + fshr16(longint'(d16) * dt), 16);
      r.col[16*i +: 16] = c[15:0];
    end
    a32 = q.size[31:0];
    b32 = q.size[63:32];
    sz = satw(longint'(a32) + fshr16(longint'(b32) * dt), 32);
    if (sz < 0) sz = 0;
    a32 = q.spin[31:0];
    b32 = q.spin[63:32];
    rot = satw(longint'(a32) + fshr16(longint'(b32) * dt), 32);
    r.alive = 1'b1;
    r.life = q.life - {8'd0, dt_q};
    r.size = sz[30:0];
    r.rot = rot[31:0];
    return r;
  endfunction

  // expected update store
  class update_scoreboard;
    update_t pending[$];
    function void note_particle(input particle_t q);
      pending = {pending, advance_particle(q)};
    endfunction
    task check_update(input update_t g);
      update_t w;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      w = pending.pop_front();
      if (g.alive !== w.alive) report("alive", g.alive, w.alive);
      if (g.life !== w.life) report("life", g.life, w.life);
      if (g.pos !== w.pos) report("position", g.pos, w.pos);
      if (g.vel !== w.vel) report("velocity", g.vel, w.vel);
      if (g.draw !== w.draw) report("draw", g.draw, w.draw);
      if (g.col !== w.col) report("color", g.col, w.col);
      if (g.size !== w.size) report("size", g.size, w.size);
      if (g.rot !== w.rot) report("rotation", g.rot, w.rot);
    endtask
  endclass

  update_scoreboard sb;

  gravity_particle_update_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .life_left_i(cur.life), .local_position_i(cur.pos), .velocity_i(cur.vel),
    .start_position_i(cur.st), .radial_accel_i(cur.ar), .tangential_accel_i(cur.at),
    .color_i(cur.col), .color_step_i(cur.dcol), .size_pair_i(cur.size),
    .spin_pair_i(cur.spin),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .alive_o(alive), .new_life_left_o(o_life), .new_local_position_o(o_pos),
    .new_velocity_o(o_vel), .draw_position_o(o_draw), .new_color_o(o_col),
    .new_size_o(o_size), .new_rotation_o(o_rot)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stalls, long hold-off when asked
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_update('{alive, o_life, o_pos, o_vel, o_draw, o_col, o_size, o_rot});
    end
    out_ready <= !rx_hold && (rx_calm || $urandom_range(99) >= 8);
  end

  task automatic write_reg(input gpup_pkg::cfg_idx_e idx, input logic [62:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      gpup_pkg::CFG_TIME_STEP: dt_q = val[15:0];
      gpup_pkg::CFG_GRAVITY: grav_q = val;
      gpup_pkg::CFG_EMITTER: emit_q = val;
      default: follow_q = val[0];
    endcase
  endtask

  task automatic send_particle(input particle_t q);
    while (!tx_calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cur <= q;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_particle(q);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [62:0] rvec(input int mode);
    logic [62:0] r;
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0: r[i*21 +: 21] = 21'($urandom_range(0, 512)) - 21'd256;
        1: r[i*21 +: 21] = $urandom_range(0, 1) ? 21'h0fffff : 21'h100000;
        default: r[i*21 +: 21] = 21'($urandom);
      endcase
    end
    return r;
  endfunction

  function automatic particle_t rand_particle();
    particle_t q;
    int m;
    m = $urandom_range(0, 9) == 0 ? 1 : ($urandom_range(0, 2) == 0 ? 0 : 2);
    q.life = $urandom_range(0, 5) == 0 ? 24'($urandom_range(0, 65535)) : 24'($urandom);
    q.pos = $urandom_range(0, 15) == 0 ? 63'd0 : rvec(m);
    q.vel = rvec(m);
    q.st = rvec(2);
    q.ar = 21'($urandom);
    q.at = 21'($urandom);
    q.col = {$urandom, $urandom};
    q.dcol = {$urandom, $urandom};
    q.size = {$urandom, $urandom};
    q.spin = {$urandom, $urandom};
    return q;
  endfunction

  function automatic particle_t edge_particle(input int k);
    particle_t q;
    logic [63:0] all1;
    all1 = k[0] ? '1 : '0;
    q.life = k[1] ? 24'hffffff : 24'd1;
    q.pos = (k % 5 == 0) ? 63'd0 : (k[0] ? {3{21'h0fffff}} : {3{21'h100000}});
    if (k == 3) q.pos = 63'h7fff_ffff_ffff_ffff;
    q.vel = k[2] ? {3{21'h0fffff}} : {3{21'h100000}};
    q.st = k[3] ? {3{21'h100000}} : {3{21'h0fffff}};
    q.ar = k[1] ? 21'sh0fffff : 21'sh100000;
    q.at = k[2] ? 21'sh100000 : 21'sh0fffff;
    q.col = all1 ^ {4{16'h8000}};
    q.dcol = k[1] ? {4{16'h7fff}} : {4{16'h8000}};
    q.size = k[2] ? {32'h7fffffff, 32'h7fffffff} : {32'h80000000, 32'h00000010};
    q.spin = k[3] ? {32'h7fffffff, 32'h7fffffff} : {32'h80000000, 32'h80000000};
    return q;
  endfunction

  // stimulus
  initial begin
    particle_t q;
    sb = new();
    errors = 0;
    rx_hold = 0;
    rx_calm = 0;
    tx_calm = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = gpup_pkg::CFG_TIME_STEP;
    cfg_data = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    cur = '{default: '0};
    dt_q = 0;
    grav_q = 0;
    emit_q = 0;
    follow_q = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes with largest frame time, following emitter
    write_reg(gpup_pkg::CFG_TIME_STEP, 63'hffff);
    write_reg(gpup_pkg::CFG_GRAVITY, {21'h0fffff, 21'h100000, 21'h0fffff});
    write_reg(gpup_pkg::CFG_EMITTER, {21'h100000, 21'h0fffff, 21'h100000});
    write_reg(gpup_pkg::CFG_FOLLOW, 63'd1);
    for (int k = 0; k < 16; k++) send_particle(edge_particle(k));
    q = edge_particle(2);
    q.life = 24'h00ffff;
    send_particle(q);
    q.life = 24'h010000;
    send_particle(q);
    go_idle();

    // random phases over several settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_reg(gpup_pkg::CFG_TIME_STEP, 63'd0);
        1: write_reg(gpup_pkg::CFG_TIME_STEP, 63'd1092);
        default: write_reg(gpup_pkg::CFG_TIME_STEP, 63'($urandom_range(0, 65535)));
      endcase
      write_reg(gpup_pkg::CFG_GRAVITY, ph == 0 ? 63'd0 : rvec(ph == 1 ? 1 : 2));
      write_reg(gpup_pkg::CFG_EMITTER, rvec(2));
      write_reg(gpup_pkg::CFG_FOLLOW, 63'(ph % 2));
      tx_calm = (ph == 2);
      rx_calm = (ph == 2);
      if (ph == 3) begin
        fork
          begin
            rx_hold = 1;
            repeat (300) @(posedge clk);
            rx_hold = 0;
          end
        join_none
      end
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        send_particle(rand_particle());
        // pause until everything is back
        if (ph == 4 && n == 60) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      go_idle();
    end

    if (errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
